/* hw/rtl/bblru_pkg.sv */
// Package for the byte-budget LRU table.
// Holds opcode and result codes, controller states and the cell structs.
// No dependencies.
package bblru_pkg;

    localparam int KEY_W  = 64;
    localparam int SIZE_W = 26;
    localparam int TIME_W = 40;
    localparam int WORD_W = 32;
    // slot index width, wide enough for tables of up to 64 entries
    localparam int SLOT_W = 6;
    localparam logic [WORD_W-1:0] BUDGET_RESET = 32'd268435456;

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_COMMIT = 2'd1,
        OP_REMOVE = 2'd2,
        OP_NONE   = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        KIND_HIT       = 3'd0,
        KIND_MISS      = 3'd1,
        KIND_EVICTED   = 3'd2,
        KIND_COMMITTED = 3'd3,
        KIND_REMOVED   = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        CMD_NONE,
        CMD_INVAL,
        CMD_TOUCH,
        CMD_WRITE
    } cmd_kind_t;

    // broadcast from controller to every cell
    typedef struct packed {
        cmd_kind_t          kind;
        logic [SLOT_W-1:0]  idx;
        logic [KEY_W-1:0]   key_hi;
        logic [KEY_W-1:0]   key_lo;
        logic [SIZE_W-1:0]  size;
        logic [TIME_W-1:0]  stamp;
    } cell_cmd_t;

    // running search result handed from cell to cell
    typedef struct packed {
        logic               m_found;
        logic [SLOT_W-1:0]  m_idx;
        logic [SIZE_W-1:0]  m_size;
        logic               o_found;
        logic [SLOT_W-1:0]  o_idx;
        logic [TIME_W-1:0]  o_time;
        logic [KEY_W-1:0]   o_key_hi;
        logic [KEY_W-1:0]   o_key_lo;
        logic [SIZE_W-1:0]  o_size;
        logic               f_found;
        logic [SLOT_W-1:0]  f_idx;
    } scan_t;

endpackage

/* hw/rtl/bblru_if.sv */
// Channel interfaces for the byte-budget LRU table.
// Depends on bblru_pkg.
interface bblru_in_if;
    import bblru_pkg::*;
    logic              valid;
    logic              ready;
    logic [1:0]        opcode;
    logic [KEY_W-1:0]  key_hi;
    logic [KEY_W-1:0]  key_lo;
    logic [SIZE_W-1:0] item_size;
    logic [TIME_W-1:0] now_time;
    modport source (output valid, opcode, key_hi, key_lo, item_size, now_time, input ready);
    modport sink   (input valid, opcode, key_hi, key_lo, item_size, now_time, output ready);
endinterface

interface bblru_out_if;
    import bblru_pkg::*;
    logic              valid;
    logic              ready;
    logic [2:0]        kind;
    logic [KEY_W-1:0]  out_key_hi;
    logic [KEY_W-1:0]  out_key_lo;
    logic [SIZE_W-1:0] out_size;
    logic              found;
    logic              last;
    modport source (output valid, kind, out_key_hi, out_key_lo, out_size, found, last,
                    input ready);
    modport sink   (input valid, kind, out_key_hi, out_key_lo, out_size, found, last,
                    output ready);
endinterface

/* hw/rtl/bblru_cell.sv */
// One slot of the table plus its stage of the search chain.
// Depends on bblru_pkg.
module bblru_cell
    import bblru_pkg::*;
#(
    parameter logic [SLOT_W-1:0] IDX = 6'd0
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  cell_cmd_t         cmd,
    input  logic [KEY_W-1:0]  srch_hi,
    input  logic [KEY_W-1:0]  srch_lo,
    input  scan_t             scan_in,
    output scan_t             scan_out
);

    logic              valid_reg;
    logic [KEY_W-1:0]  key_hi_reg;
    logic [KEY_W-1:0]  key_lo_reg;
    logic [SIZE_W-1:0] size_reg;
    logic [TIME_W-1:0] time_reg;
    scan_t             scan_reg;
    scan_t             scan_next;
    logic              sel;

    assign sel = (cmd.idx == IDX);

    // slot valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (sel && cmd.kind == CMD_INVAL)
        begin
            valid_reg <= 1'b0;
        end
        else if (sel && cmd.kind == CMD_WRITE)
        begin
            valid_reg <= 1'b1;
        end
    end

    // slot payload
    always_ff @(posedge clk)
    begin
        if (sel && cmd.kind == CMD_WRITE)
        begin
            key_hi_reg <= cmd.key_hi;
            key_lo_reg <= cmd.key_lo;
            size_reg   <= cmd.size;
            time_reg   <= cmd.stamp;
        end
        else if (sel && cmd.kind == CMD_TOUCH)
        begin
            time_reg <= cmd.stamp;
        end
    end

    // fold this slot into the search; earlier slots win ties
    always_comb
    begin
        scan_next = scan_in;
        if (valid_reg && !scan_in.m_found && key_hi_reg == srch_hi && key_lo_reg == srch_lo)
        begin
            scan_next.m_found = 1'b1;
            scan_next.m_idx   = IDX;
            scan_next.m_size  = size_reg;
        end
        if (valid_reg && (!scan_in.o_found || time_reg < scan_in.o_time))
        begin
            scan_next.o_found  = 1'b1;
            scan_next.o_idx    = IDX;
            scan_next.o_time   = time_reg;
            scan_next.o_key_hi = key_hi_reg;
            scan_next.o_key_lo = key_lo_reg;
            scan_next.o_size   = size_reg;
        end
        if (!valid_reg && !scan_in.f_found)
        begin
            scan_next.f_found = 1'b1;
            scan_next.f_idx   = IDX;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg <= scan_next;
    end

    assign scan_out = scan_reg;

endmodule

/* hw/rtl/byte_budget_lru_table.sv */
// Top level of the byte-budget LRU table: controller, budget register, cell chain.
// Depends on bblru_pkg, bblru_if and bblru_cell.
//
// Channel   Modport  Transfer moves
// in_ch     sink     opcode, key_hi, key_lo, item_size, now_time
// out_ch    source   kind, out_key_hi, out_key_lo, out_size, found, last
// cfg_we    input    cfg_wdata -> byte_budget
//
// Each result costs one search pass through the cell chain (ST_SCAN), a decide
// step (ST_DECIDE) and an output step (ST_OUT) held until out_ch.ready; an item
// repeats these for every result it yields, after it is accepted in ST_IDLE.
// Items are taken one at a time; in_ch.ready is high only while idle.
// A stalled output holds the controller; no clearing pass after reset.
module byte_budget_lru_table
    import bblru_pkg::*;
#(
    parameter int ENTRIES = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [WORD_W-1:0] cfg_wdata,
    bblru_in_if.sink          in_ch,
    bblru_out_if.source       out_ch
);

    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ENTRIES - 1);

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [WORD_W-1:0] budget_reg;
    logic [WORD_W-1:0] bytes_reg, bytes_next;
    logic [1:0]        op_reg;
    logic [KEY_W-1:0]  key_hi_reg, key_lo_reg;
    logic [SIZE_W-1:0] size_reg;
    logic [TIME_W-1:0] time_reg;
    logic              more_reg, more_next;
    logic              ov_reg, ov_next;
    logic [2:0]        kind_reg, kind_next;
    logic [KEY_W-1:0]  okh_reg, okh_next, okl_reg, okl_next;
    logic [SIZE_W-1:0] osz_reg, osz_next;
    logic              fnd_reg, fnd_next, last_reg, last_next;
    logic              load_out;
    logic              in_xfer;
    logic [WORD_W:0]   need;
    cell_cmd_t         cmd;
    scan_t             chain [ENTRIES+1];
    scan_t             res;

    assign in_xfer = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (state_reg == ST_IDLE);
    assign res = chain[ENTRIES];
    assign need = {1'b0, bytes_reg} + {{(WORD_W + 1 - SIZE_W){1'b0}}, size_reg};

    // chain head starts empty
    assign chain[0] = '0;

    genvar g;
    generate
        for (g = 0; g < ENTRIES; g++)
        begin : g_cell
            bblru_cell #(.IDX(SLOT_W'(g))) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .cmd      (cmd),
                .srch_hi  (key_hi_reg),
                .srch_lo  (key_lo_reg),
                .scan_in  (chain[g]),
                .scan_out (chain[g+1])
            );
        end
    endgenerate

    // budget register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            budget_reg <= BUDGET_RESET;
        end
        else if (cfg_we)
        begin
            budget_reg <= cfg_wdata;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            bytes_reg <= '0;
            more_reg  <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            bytes_reg <= bytes_next;
            more_reg  <= more_next;
            ov_reg    <= ov_next;
        end
    end

    // item and result payload
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            op_reg     <= in_ch.opcode;
            key_hi_reg <= in_ch.key_hi;
            key_lo_reg <= in_ch.key_lo;
            size_reg   <= in_ch.item_size;
            time_reg   <= in_ch.now_time;
        end
        if (load_out)
        begin
            kind_reg <= kind_next;
            okh_reg  <= okh_next;
            okl_reg  <= okl_next;
            osz_reg  <= osz_next;
            fnd_reg  <= fnd_next;
            last_reg <= last_next;
        end
    end

    // next state, cell commands and results
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        bytes_next = bytes_reg;
        more_next  = more_reg;
        ov_next    = ov_reg;
        load_out   = 1'b0;
        kind_next  = KIND_MISS;
        okh_next   = key_hi_reg;
        okl_next   = key_lo_reg;
        osz_next   = '0;
        fnd_next   = 1'b0;
        last_next  = 1'b1;
        cmd        = '0;
        cmd.kind   = CMD_NONE;
        cmd.key_hi = key_hi_reg;
        cmd.key_lo = key_lo_reg;
        cmd.size   = size_reg;
        cmd.stamp  = time_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (in_xfer)
                begin
                    ov_next = ({6'd0, in_ch.item_size} > budget_reg);
                    state_next = (in_ch.opcode == OP_NONE) ? ST_IDLE : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (cnt_reg == CNT_LAST)
                begin
                    cnt_next   = '0;
                    state_next = ST_DECIDE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DECIDE:
            begin
                load_out   = 1'b1;
                state_next = ST_OUT;
                more_next  = 1'b0;
                case (op_reg)
                    OP_LOOKUP:
                    begin
                        if (res.m_found)
                        begin
                            cmd.kind  = CMD_TOUCH;
                            cmd.idx   = res.m_idx;
                            kind_next = KIND_HIT;
                            osz_next  = res.m_size;
                        end
                    end
                    OP_REMOVE:
                    begin
                        kind_next = KIND_REMOVED;
                        if (res.m_found)
                        begin
                            cmd.kind   = CMD_INVAL;
                            cmd.idx    = res.m_idx;
                            bytes_next = bytes_reg - {6'd0, res.m_size};
                            osz_next   = res.m_size;
                            fnd_next   = 1'b1;
                        end
                    end
                    default:
                    begin
                        if ((!ov_reg && need > {1'b0, budget_reg} && res.o_found)
                            || (!res.m_found && !res.f_found))
                        begin
                            // evict the oldest, then search again
                            cmd.kind   = CMD_INVAL;
                            cmd.idx    = res.o_idx;
                            bytes_next = bytes_reg - {6'd0, res.o_size};
                            kind_next  = KIND_EVICTED;
                            okh_next   = res.o_key_hi;
                            okl_next   = res.o_key_lo;
                            osz_next   = res.o_size;
                            last_next  = 1'b0;
                            more_next  = 1'b1;
                        end
                        else
                        begin
                            cmd.kind  = CMD_WRITE;
                            kind_next = KIND_COMMITTED;
                            osz_next  = size_reg;
                            if (res.m_found)
                            begin
                                cmd.idx    = res.m_idx;
                                bytes_next = bytes_reg - {6'd0, res.m_size}
                                             + {6'd0, size_reg};
                            end
                            else
                            begin
                                cmd.idx    = res.f_idx;
                                bytes_next = need[WORD_W-1:0];
                            end
                        end
                    end
                endcase
            end
            ST_OUT:
            begin
                if (out_ch.ready)
                begin
                    state_next = more_reg ? ST_SCAN : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_ch.valid      = (state_reg == ST_OUT);
    assign out_ch.kind       = kind_reg;
    assign out_ch.out_key_hi = okh_reg;
    assign out_ch.out_key_lo = okl_reg;
    assign out_ch.out_size   = osz_reg;
    assign out_ch.found      = fnd_reg;
    assign out_ch.last       = last_reg;

    // checks
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ch.ready && out_ch.valid))
        else $error("input taken while a result is pending");
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_LAST)
        else $error("search counter out of range");
    a_more_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.ready && !out_ch.last) |=> state_reg == ST_SCAN)
        else $error("non-final result not followed by a search");
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.ready && out_ch.last) |=> state_reg == ST_IDLE)
        else $error("final result not followed by idle");

endmodule
